>>> sv/tmtw_pkg.sv
// Shared types and constants for the text-mode terminal writer.
`default_nettype none

package tmtw_pkg;

    // Item actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Character codes with special handling
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // Attribute after reset and the cell every location holds after reset
    localparam logic [7:0]  RESET_COLOR = 8'h0F;
    localparam logic [15:0] CELL_RESET  = {RESET_COLOR, CH_SPACE};

    // Configuration port: byte address width and register index
    localparam int         APB_AW         = 3;
    localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } tmtw_in_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
    } tmtw_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SWEEP_INIT,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } sweep_mode_t;

    // Controller to datapath
    typedef struct packed {
        logic        load_item;
        logic        exec;
        logic        sweep_run;
        sweep_mode_t sweep_mode;
        logic        load_out;
    } tmtw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       scroll;
        logic       sweep_last;
    } tmtw_stat_t;

endpackage

`default_nettype wire

>>> sv/tmtw_ctrl.sv
// Controller state machine for the text-mode terminal writer.
`default_nettype none

module tmtw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    output logic                    result_valid,
    input  wire logic               result_ready,
    input  wire tmtw_pkg::tmtw_stat_t stat,
    output tmtw_pkg::tmtw_cmd_t     cmd
);
    import tmtw_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        item_ready     = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.exec       = 1'b0;
        cmd.sweep_run  = 1'b0;
        cmd.sweep_mode = SWEEP_INIT;
        cmd.load_out   = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_mode = SWEEP_INIT;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.action == ACT_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if (stat.scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_mode = SWEEP_SCROLL;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_mode = SWEEP_CLEAR;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the result to the output register, take the next item alongside
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    item_ready   = 1'b1;
                    if (item_valid)
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Set on load, drop on transfer
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

>>> sv/tmtw_datapath.sv
// Datapath for the text-mode terminal writer: cursor, screen memory, sweep counter, result.
`default_nettype none

module tmtw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tmtw_pkg::tmtw_cmd_t  cmd,
    output tmtw_pkg::tmtw_stat_t      stat,
    input  wire tmtw_pkg::tmtw_in_t   item,
    input  wire logic [7:0]           text_color,
    output tmtw_pkg::tmtw_out_t       result
);
    import tmtw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int LAST  = (ROWS - 1) * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    logic [15:0]     screen_mem [CELLS];
    logic [15:0]     rd_data_reg;

    tmtw_in_t        item_reg;
    tmtw_out_t       result_reg, result_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    // Character handling
    logic            row_last, col_last, advance, exec_we, scroll;
    logic [RW-1:0]   cur_row_n, wr_row;
    logic [CW-1:0]   cur_col_n, wr_col;
    logic [7:0]      wr_char;
    logic [31:0]     exec_addr_w, read_addr_w, row_wide, col_wide;
    logic            read_hit, sweep_last;

    // Sweep and memory port
    logic [CNTW-1:0] sw_wr_idx, sw_rd_idx;
    logic [15:0]     blank_cell;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [15:0]     mem_wd;

    // Work out the cursor move and the cell to write for a character
    always_comb
    begin
        row_last  = (row_reg == RW'(ROWS - 1));
        col_last  = (col_reg == CW'(COLUMNS - 1));
        cur_row_n = row_reg;
        cur_col_n = col_reg;
        advance   = 1'b0;
        exec_we   = 1'b0;
        wr_row    = row_reg;
        wr_col    = col_reg;
        wr_char   = item_reg.char_code;

        case (item_reg.char_code)
            CH_NEWLINE:
            begin
                cur_col_n = '0;
                advance   = 1'b1;
            end
            CH_RETURN:
            begin
                cur_col_n = '0;
            end
            CH_BACKSPACE:
            begin
                // Step back, across a row boundary if needed, then blank that cell
                exec_we = 1'b1;
                wr_char = CH_SPACE;
                if (col_reg != '0)
                begin
                    cur_col_n = col_reg - CW'(1);
                end
                else if (row_reg != '0)
                begin
                    cur_row_n = row_reg - RW'(1);
                    cur_col_n = CW'(COLUMNS - 1);
                end
                wr_row = cur_row_n;
                wr_col = cur_col_n;
            end
            default:
            begin
                exec_we = 1'b1;
                if (col_last)
                begin
                    cur_col_n = '0;
                    advance   = 1'b1;
                end
                else
                begin
                    cur_col_n = col_reg + CW'(1);
                end
            end
        endcase

        // Past the last row the screen scrolls and the row stays put
        scroll = advance && row_last;
        if (advance && !row_last)
        begin
            cur_row_n = row_reg + RW'(1);
        end
    end

    assign exec_addr_w = 32'(wr_row) * 32'(COLUMNS) + 32'(wr_col);
    assign read_addr_w = 32'(item_reg.read_row) * 32'(COLUMNS) + 32'(item_reg.read_column);
    assign read_hit    = (32'(item_reg.read_row) < 32'(ROWS))
                      && (32'(item_reg.read_column) < 32'(COLUMNS));
    assign sweep_last  = (cnt_reg == CNTW'(CELLS));

    assign stat.action     = item_reg.action;
    assign stat.scroll     = (item_reg.action == ACT_WRITE) && scroll;
    assign stat.sweep_last = sweep_last;

    // Sweep addressing: write trails the registered read, read runs one row ahead
    assign sw_wr_idx  = cnt_reg - CNTW'(1);
    assign sw_rd_idx  = cnt_reg + CNTW'(COLUMNS);
    assign blank_cell = {text_color, CH_SPACE};

    // Select the memory port's user
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = blank_cell;
        mem_re = 1'b0;
        mem_ra = '0;
        if (cmd.exec)
        begin
            if ((item_reg.action == ACT_WRITE) && exec_we)
            begin
                mem_we = 1'b1;
                mem_wa = exec_addr_w[AW-1:0];
                mem_wd = {text_color, wr_char};
            end
            if ((item_reg.action == ACT_READ) && read_hit)
            begin
                mem_re = 1'b1;
                mem_ra = read_addr_w[AW-1:0];
            end
        end
        else if (cmd.sweep_run)
        begin
            mem_we = (cnt_reg != '0);
            mem_wa = sw_wr_idx[AW-1:0];
            case (cmd.sweep_mode)
                SWEEP_INIT:
                begin
                    mem_wd = CELL_RESET;
                end
                SWEEP_CLEAR:
                begin
                    mem_wd = blank_cell;
                end
                SWEEP_SCROLL:
                begin
                    // Copy each line up one row, blank the bottom line
                    mem_wd = (sw_wr_idx < CNTW'(LAST)) ? rd_data_reg : blank_cell;
                    mem_re = (cnt_reg < CNTW'(LAST));
                    mem_ra = sw_rd_idx[AW-1:0];
                end
                default:
                begin
                    mem_wd = blank_cell;
                end
            endcase
        end
    end

    // Screen memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[mem_ra];
        end
    end

    // Advance the sweep counter, wrap at the end
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.sweep_run)
        begin
            cnt_next = sweep_last ? '0 : cnt_reg + CNTW'(1);
        end
    end

    // Update the cursor
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.exec)
        begin
            if (item_reg.action == ACT_WRITE)
            begin
                row_next = cur_row_n;
                col_next = cur_col_n;
            end
            else if (item_reg.action == ACT_CLEAR)
            begin
                row_next = '0;
                col_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            cnt_reg <= cnt_next;
        end
    end

    // Build the result from the finished item
    assign row_wide = 32'(row_reg);
    assign col_wide = 32'(col_reg);

    always_comb
    begin
        result_next.cell_value    = ((item_reg.action == ACT_READ) && read_hit)
                                  ? rd_data_reg : 16'd0;
        result_next.cursor_row    = row_wide[4:0];
        result_next.cursor_column = col_wide[6:0];
    end

    // Hold the item and the result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.load_out)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> sv/text_mode_terminal_writer_core.sv
// Top level of the text-mode terminal writer: configuration register, controller, datapath.
//
// Keeps a ROWS x COLUMNS screen of 16-bit cells (attribute in 15..8, character
// in 7..0) and a cursor. Each item writes a character (newline, return and
// backspace are handled as controls), reads one cell, or clears the screen,
// and returns one result with the cursor after the item. A character, read or
// no-op item passes the item register, the execute and done states and the
// result register; the next item is taken as the result is registered, when
// the output register is free. A scroll or a clear adds a sweep of the screen
// memory, one cell per cycle. After reset the memory is swept to spaces in white
// on black, during which no item is taken; text_color writes are taken at any time.
`default_nettype none

module text_mode_terminal_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire tmtw_pkg::tmtw_in_t            item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output tmtw_pkg::tmtw_out_t                result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tmtw_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import tmtw_pkg::*;

    logic [7:0] text_color_reg, text_color_next;
    logic       apb_write;
    logic       sel_color;
    tmtw_cmd_t  cmd;
    tmtw_stat_t stat;

    // Decode the configuration access
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;
    assign sel_color = (paddr[APB_AW-1:2] == REG_TEXT_COLOR);

    assign text_color_next = (apb_write && sel_color) ? pwdata[7:0] : text_color_reg;
    assign prdata          = sel_color ? {24'd0, text_color_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    tmtw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    tmtw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .item       (item),
        .text_color (text_color_reg),
        .result     (result)
    );

endmodule

`default_nettype wire

>>> sv/tmtw_checker.sv
// Port-level checks for the text-mode terminal writer and their binding.
`default_nettype none

module tmtw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire logic                item_ready,
    input  wire logic                result_valid,
    input  wire logic                result_ready,
    input  wire tmtw_pkg::tmtw_out_t result
);
    import tmtw_pkg::*;

    logic       item_xfer, result_xfer;
    logic [1:0] outst_reg, outst_next;

    // Count items taken whose result is not yet transferred
    assign item_xfer   = item_valid && item_ready;
    assign result_xfer = result_valid && result_ready;

    always_comb
    begin
        outst_next = outst_reg;
        if (item_xfer && !result_xfer)
        begin
            outst_next = outst_reg + 2'd1;
        end
        else if (!item_xfer && result_xfer)
        begin
            outst_next = outst_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= 2'd0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    // One item at work plus one result waiting, never more
    a_no_third_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && !result_xfer) |-> (outst_reg <= 2'd1))
        else $error("item taken with two items outstanding");

    // No result without an item behind it
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (outst_reg != 2'd0))
        else $error("result shown with no item outstanding");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("stalled result dropped or changed");

    // Reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((32'(result.cursor_row) < 32'(ROWS))
                       && (32'(result.cursor_column) < 32'(COLUMNS))))
        else $error("cursor reported off the screen");

endmodule

bind text_mode_terminal_writer_core tmtw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmtw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
